// ----- src/gbn_link_pkg.sv -----
// Shared types and constants for the go-back-N link endpoint.
// Depends on nothing; every other file in src uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gbn_link_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int TIMER_W = 32;

    // Item command codes.
    localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Frame kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 32'd3000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rx_update;
        logic ack_free;
        logic tick_start;
        logic scan_step;
        logic go_back;
        logic rs_read;
        logic emit_offer;
        logic emit_resend;
        logic emit_ackframe;
        logic emit_plain;
    } gbn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             window_full;
        logic             count_zero;
        logic             ack_in_window;
        logic             expired;
        logic             rx_was_data;
        logic             out_free;
        logic             scan_done;
        logic             rs_last;
    } gbn_stat_t;

endpackage

`default_nettype wire

// ----- src/gbn_link_dp.sv -----
// Datapath of the go-back-N link endpoint: sequence state, send buffer,
// timer memory, timeout comparator and the output register. Uses gbn_link_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_link_dp #(
    parameter int SEQ_BITS = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gbn_link_pkg::gbn_cmd_t                ctl,
    output gbn_link_pkg::gbn_stat_t               stat,
    input  logic [gbn_link_pkg::CMD_W-1:0]        cmd,
    input  logic [gbn_link_pkg::BYTE_W-1:0]       pkt_data,
    input  logic                                  frame_kind,
    input  logic [SEQ_BITS-1:0]                   frame_seq,
    input  logic [SEQ_BITS-1:0]                   frame_ack,
    input  logic [gbn_link_pkg::BYTE_W-1:0]       frame_data,
    input  logic                                  cfg_valid,
    input  logic [gbn_link_pkg::TIMER_W-1:0]      cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  tx_valid,
    output logic                                  tx_kind,
    output logic [SEQ_BITS-1:0]                   tx_seq,
    output logic [SEQ_BITS-1:0]                   tx_ack,
    output logic [gbn_link_pkg::BYTE_W-1:0]       tx_data,
    output logic                                  deliver_valid,
    output logic [gbn_link_pkg::BYTE_W-1:0]       deliver_data,
    output logic                                  accepted,
    output logic                                  window_open,
    output logic                                  last
);

    localparam int SEQ_SPACE  = 1 << SEQ_BITS;
    localparam int WINDOW_MAX = SEQ_SPACE - 1;
    localparam int CNT_W      = SEQ_BITS + 1;
    localparam logic [SEQ_BITS-1:0] SEQ_ONE   = SEQ_BITS'(1);
    localparam logic [SEQ_BITS-1:0] COUNT_MAX = SEQ_BITS'(WINDOW_MAX);
    localparam logic [CNT_W-1:0]    SCAN_END  = CNT_W'(SEQ_SPACE);

    // Latched item.
    logic [gbn_link_pkg::CMD_W-1:0]   item_cmd_reg;
    logic [gbn_link_pkg::BYTE_W-1:0]  pkt_reg;
    logic                             fkind_reg;
    logic [SEQ_BITS-1:0]              fseq_reg;
    logic [SEQ_BITS-1:0]              fack_reg;
    logic [gbn_link_pkg::BYTE_W-1:0]  fdata_reg;

    // Link state.
    logic [gbn_link_pkg::TIMER_W-1:0] interval_reg;
    logic [SEQ_BITS-1:0]              nss_reg;
    logic [SEQ_BITS-1:0]              oldest_reg;
    logic [SEQ_BITS-1:0]              ers_reg;
    logic [SEQ_BITS-1:0]              count_reg;
    logic                             lrwd_reg;
    logic [SEQ_SPACE-1:0]             active_reg;
    logic [gbn_link_pkg::TIMER_W-1:0] tick_reg;

    logic [gbn_link_pkg::BYTE_W-1:0]  send_buf_mem [SEQ_SPACE];
    logic [gbn_link_pkg::TIMER_W-1:0] timer_mem [SEQ_SPACE];

    // Work registers.
    logic [gbn_link_pkg::BYTE_W-1:0]  buf_rd_reg;
    logic [gbn_link_pkg::TIMER_W-1:0] rd_start_reg;
    logic                             rd_act_reg;
    logic                             cmp_valid_reg;
    logic                             expired_reg;
    logic [CNT_W-1:0]                 scan_cnt_reg;
    logic [SEQ_BITS-1:0]              rs_cnt_reg;
    logic                             dv_reg;
    logic [gbn_link_pkg::BYTE_W-1:0]  dd_reg;

    // Output register.
    logic                             out_valid_reg;
    logic                             tx_valid_reg;
    logic                             tx_kind_reg;
    logic [SEQ_BITS-1:0]              tx_seq_reg;
    logic [SEQ_BITS-1:0]              tx_ack_reg;
    logic [gbn_link_pkg::BYTE_W-1:0]  tx_data_reg;
    logic                             dv_out_reg;
    logic [gbn_link_pkg::BYTE_W-1:0]  dd_out_reg;
    logic                             acc_reg;
    logic                             wo_reg;
    logic                             last_reg;

    logic                             tx_valid_next;
    logic                             tx_kind_next;
    logic [SEQ_BITS-1:0]              tx_seq_next;
    logic [SEQ_BITS-1:0]              tx_ack_next;
    logic [gbn_link_pkg::BYTE_W-1:0]  tx_data_next;
    logic                             dv_out_next;
    logic [gbn_link_pkg::BYTE_W-1:0]  dd_out_next;
    logic                             acc_next;
    logic                             wo_next;
    logic                             last_next;

    logic [SEQ_BITS-1:0]              ack_dist;
    logic [SEQ_BITS-1:0]              win_len;
    logic                             ack_in_window;
    logic [gbn_link_pkg::TIMER_W-1:0] timer_age;
    logic                             timer_hit;
    logic                             out_free;
    logic                             rs_last;
    logic                             rx_match;
    logic                             scan_rd;
    logic                             timer_we;
    logic                             emit_any;
    logic [SEQ_BITS-1:0]              scan_idx;
    logic [SEQ_BITS-1:0]              ack_field;

    // The ack number lies in the span of sent, unacked numbers exactly when
    // its distance from the oldest one is below the span length.
    assign ack_dist      = fack_reg - oldest_reg;
    assign win_len       = nss_reg - oldest_reg;
    assign ack_in_window = ack_dist < win_len;

    assign timer_age = tick_reg - rd_start_reg;
    assign timer_hit = rd_act_reg && (timer_age > interval_reg);

    assign out_free  = !out_valid_reg || out_ready;
    assign rs_last   = (CNT_W'(rs_cnt_reg) + CNT_W'(1)) == CNT_W'(count_reg);
    assign rx_match  = fseq_reg == ers_reg;
    assign scan_rd   = ctl.scan_step && (scan_cnt_reg < SCAN_END);
    assign scan_idx  = scan_cnt_reg[SEQ_BITS-1:0];
    assign timer_we  = ctl.emit_offer || ctl.emit_resend;
    assign emit_any  = ctl.emit_offer || ctl.emit_resend || ctl.emit_ackframe
                     || ctl.emit_plain;
    assign ack_field = ers_reg - SEQ_ONE;

    assign stat.item_cmd      = item_cmd_reg;
    assign stat.window_full   = count_reg == COUNT_MAX;
    assign stat.count_zero    = count_reg == '0;
    assign stat.ack_in_window = ack_in_window;
    assign stat.expired       = expired_reg;
    assign stat.rx_was_data   = lrwd_reg;
    assign stat.out_free      = out_free;
    assign stat.scan_done     = (scan_cnt_reg == SCAN_END) && !cmp_valid_reg;
    assign stat.rs_last       = rs_last;

    always_comb
    begin
        tx_valid_next = 1'b0;
        tx_kind_next  = gbn_link_pkg::KIND_DATA;
        tx_seq_next   = '0;
        tx_ack_next   = '0;
        tx_data_next  = '0;
        dv_out_next   = 1'b0;
        dd_out_next   = '0;
        acc_next      = 1'b0;
        wo_next       = count_reg != COUNT_MAX;
        last_next     = 1'b1;
        if (ctl.emit_offer)
        begin
            tx_valid_next = 1'b1;
            tx_seq_next   = nss_reg;
            tx_ack_next   = ack_field;
            tx_data_next  = pkt_reg;
            acc_next      = 1'b1;
            // The count goes up by one with this frame.
            wo_next       = count_reg != (COUNT_MAX - SEQ_ONE);
        end
        else if (ctl.emit_resend)
        begin
            tx_valid_next = 1'b1;
            tx_seq_next   = nss_reg;
            tx_ack_next   = ack_field;
            tx_data_next  = buf_rd_reg;
            last_next     = rs_last;
        end
        else if (ctl.emit_ackframe)
        begin
            tx_valid_next = 1'b1;
            tx_kind_next  = gbn_link_pkg::KIND_ACK;
            tx_seq_next   = nss_reg;
            tx_ack_next   = ack_field;
        end
        else
        begin
            dv_out_next = dv_reg;
            dd_out_next = dd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_cmd_reg <= cmd;
            pkt_reg      <= pkt_data;
            fkind_reg    <= frame_kind;
            fseq_reg     <= frame_seq;
            fack_reg     <= frame_ack;
            fdata_reg    <= frame_data;
            dv_reg       <= 1'b0;
            dd_reg       <= '0;
        end
        else if (ctl.rx_update && rx_match && (fdata_reg != '0))
        begin
            dv_reg <= 1'b1;
            dd_reg <= fdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= gbn_link_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            interval_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nss_reg    <= '0;
            oldest_reg <= '0;
            ers_reg    <= '0;
            count_reg  <= '0;
            lrwd_reg   <= 1'b0;
            active_reg <= '0;
            tick_reg   <= '0;
            rs_cnt_reg <= '0;
        end
        else
        begin
            if (ctl.emit_offer)
            begin
                count_reg           <= count_reg + SEQ_ONE;
                nss_reg             <= nss_reg + SEQ_ONE;
                lrwd_reg            <= 1'b0;
                active_reg[nss_reg] <= 1'b1;
            end
            else if (ctl.rx_update)
            begin
                if (rx_match)
                begin
                    ers_reg <= ers_reg + SEQ_ONE;
                    if (fkind_reg == gbn_link_pkg::KIND_DATA)
                    begin
                        lrwd_reg <= 1'b1;
                    end
                end
            end
            else if (ctl.ack_free)
            begin
                // Ack frames use numbers without being counted, so the count
                // stops at zero.
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - SEQ_ONE;
                end
                active_reg[oldest_reg] <= 1'b0;
                oldest_reg             <= oldest_reg + SEQ_ONE;
            end
            else if (ctl.tick_start)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            else if (ctl.emit_resend)
            begin
                nss_reg             <= nss_reg + SEQ_ONE;
                rs_cnt_reg          <= rs_cnt_reg + SEQ_ONE;
                active_reg[nss_reg] <= 1'b1;
            end
            else if (ctl.emit_ackframe)
            begin
                nss_reg  <= nss_reg + SEQ_ONE;
                lrwd_reg <= 1'b0;
            end
            if (ctl.go_back)
            begin
                nss_reg    <= oldest_reg;
                rs_cnt_reg <= '0;
            end
        end
    end

    // Timer scan: one slot read per cycle, compared in the cycle after its read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            expired_reg   <= 1'b0;
        end
        else if (ctl.tick_start)
        begin
            scan_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            expired_reg   <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= scan_rd;
            if (scan_rd)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (cmp_valid_reg && timer_hit)
            begin
                expired_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_offer)
        begin
            send_buf_mem[nss_reg] <= pkt_reg;
        end
        if (ctl.rs_read)
        begin
            buf_rd_reg <= send_buf_mem[nss_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (timer_we)
        begin
            timer_mem[nss_reg] <= tick_reg;
        end
        if (scan_rd)
        begin
            rd_start_reg <= timer_mem[scan_idx];
            rd_act_reg   <= active_reg[scan_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            tx_valid_reg <= tx_valid_next;
            tx_kind_reg  <= tx_kind_next;
            tx_seq_reg   <= tx_seq_next;
            tx_ack_reg   <= tx_ack_next;
            tx_data_reg  <= tx_data_next;
            dv_out_reg   <= dv_out_next;
            dd_out_reg   <= dd_out_next;
            acc_reg      <= acc_next;
            wo_reg       <= wo_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_kind       = tx_kind_reg;
    assign tx_seq        = tx_seq_reg;
    assign tx_ack        = tx_ack_reg;
    assign tx_data       = tx_data_reg;
    assign deliver_valid = dv_out_reg;
    assign deliver_data  = dd_out_reg;
    assign accepted      = acc_reg;
    assign window_open   = wo_reg;
    assign last          = last_reg;

    a_offer_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_offer |-> count_reg != COUNT_MAX)
        else $error("offer sent with a full window");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.emit_offer, ctl.emit_resend, ctl.emit_ackframe, ctl.emit_plain}))
        else $error("more than one result loaded in a cycle");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_any |-> out_free)
        else $error("result loaded over one not yet taken");

    a_ack_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.ack_free && count_reg != '0) |=> count_reg == ($past(count_reg) - SEQ_ONE))
        else $error("freed slot did not lower the outstanding count");

    a_resend_needs_frames: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_resend |-> count_reg != '0)
        else $error("resend with nothing outstanding");

endmodule

`default_nettype wire

// ----- src/gbn_link_ctrl.sv -----
// Controller of the go-back-N link endpoint: sequences each item through
// the datapath. Uses gbn_link_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module gbn_link_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  gbn_link_pkg::gbn_stat_t stat,
    output gbn_link_pkg::gbn_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ACK_LOOP,
        S_SCAN,
        S_DECIDE,
        S_RS_READ,
        S_RS_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.item_cmd)
                    gbn_link_pkg::CMD_OFFER:
                    begin
                        if (stat.out_free)
                        begin
                            ctl.emit_offer = !stat.window_full;
                            ctl.emit_plain = stat.window_full;
                            state_next     = S_IDLE;
                        end
                    end
                    gbn_link_pkg::CMD_FRAME:
                    begin
                        ctl.rx_update = 1'b1;
                        state_next    = S_ACK_LOOP;
                    end
                    gbn_link_pkg::CMD_TICK:
                    begin
                        ctl.tick_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            ctl.emit_plain = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_ACK_LOOP:
            begin
                // One acknowledged slot is released per cycle.
                if (stat.ack_in_window)
                begin
                    ctl.ack_free = 1'b1;
                end
                else if (stat.out_free)
                begin
                    ctl.emit_plain = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (stat.expired)
                begin
                    ctl.go_back = 1'b1;
                    if (!stat.count_zero)
                    begin
                        state_next = S_RS_READ;
                    end
                    else if (stat.out_free)
                    begin
                        ctl.emit_plain = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.out_free)
                begin
                    ctl.emit_ackframe = stat.rx_was_data;
                    ctl.emit_plain    = !stat.rx_was_data;
                    state_next        = S_IDLE;
                end
            end
            S_RS_READ:
            begin
                ctl.rs_read = 1'b1;
                state_next  = S_RS_EMIT;
            end
            S_RS_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_resend = 1'b1;
                    state_next      = stat.rs_last ? S_IDLE : S_RS_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/go_back_n_link_endpoint.sv -----
// One endpoint of a go-back-N link with SEQ_BITS-bit sequence numbers and a
// window of 2**SEQ_BITS - 1 frames. Each item is an offered byte, an arrived
// frame, a time tick or an empty command, and gives one or more result items,
// the final one marked by last. An arrived frame first updates the receive
// state, then releases each send slot its ack covers. A tick runs the timer
// scan, which reads one timer slot per cycle from the timer memory; after a
// timeout each resent frame reads the send buffer before it is loaded into
// the output register. A new item is taken once the last result of the
// previous one sits in the output register. The timeout interval register
// resets to 3000 ticks; write it only while idle.
// Depends on gbn_link_pkg, gbn_link_ctrl and gbn_link_dp.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_link_endpoint #(
    parameter int SEQ_BITS = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [gbn_link_pkg::CMD_W-1:0]   cmd,
    input  logic [gbn_link_pkg::BYTE_W-1:0]  pkt_data,
    input  logic                             frame_kind,
    input  logic [SEQ_BITS-1:0]              frame_seq,
    input  logic [SEQ_BITS-1:0]              frame_ack,
    input  logic [gbn_link_pkg::BYTE_W-1:0]  frame_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gbn_link_pkg::TIMER_W-1:0] cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             tx_valid,
    output logic                             tx_kind,
    output logic [SEQ_BITS-1:0]              tx_seq,
    output logic [SEQ_BITS-1:0]              tx_ack,
    output logic [gbn_link_pkg::BYTE_W-1:0]  tx_data,
    output logic                             deliver_valid,
    output logic [gbn_link_pkg::BYTE_W-1:0]  deliver_data,
    output logic                             accepted,
    output logic                             window_open,
    output logic                             last
);

    gbn_link_pkg::gbn_cmd_t  ctl;
    gbn_link_pkg::gbn_stat_t stat;

    // The timeout register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    gbn_link_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    gbn_link_dp #(
        .SEQ_BITS (SEQ_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .pkt_data      (pkt_data),
        .frame_kind    (frame_kind),
        .frame_seq     (frame_seq),
        .frame_ack     (frame_ack),
        .frame_data    (frame_data),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .tx_valid      (tx_valid),
        .tx_kind       (tx_kind),
        .tx_seq        (tx_seq),
        .tx_ack        (tx_ack),
        .tx_data       (tx_data),
        .deliver_valid (deliver_valid),
        .deliver_data  (deliver_data),
        .accepted      (accepted),
        .window_open   (window_open),
        .last          (last)
    );

endmodule

`default_nettype wire
